/* rtl/sorted_key_table_top_defines.svh */
// Assertion macros shared by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_TOP_DEFINES_SVH
`define SORTED_KEY_TABLE_TOP_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define SKT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/skt_pkg.sv */
// Types and constants of the sorted key table.
package skt_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 31;
  localparam int YEAR_W   = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [YEAR_W-1:0] year;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [YEAR_W-1:0]   found_year;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [YEAR_W-1:0] year;
  } entry_t;

endpackage

/* rtl/sorted_key_table_top.sv */
// Sorted key table: keys kept in ascending order in one RAM, with insert, remove, lookup.
//
// Request channel req (req_valid/req_ready) carries kind, key and year; response
// channel rsp (rsp_valid/rsp_ready) returns status, found_year and entry_count,
// one response per request, in order.
// One request is worked on at a time. A binary search over the held entries
// issues one RAM read a cycle, then one probe read confirms a match.
// With N entries held and S = ceil(log2(N+1)), the search makes at most S reads.
// An insert then moves every entry above the new key up one place and writes
// the new entry below them; a remove moves every entry above the removed key
// down one place. Lookups, failed inserts/removes and unused kinds do neither.
// The shift moves one entry a cycle through the single RAM write port.
// A finished response sits in the output register; the next request is accepted
// while it waits, and the block holds the following result until rsp is taken.
// Reset (synchronous, active high) empties the table at once: the fill count
// clears and the RAM content is not touched, as only entries below the count are used.
module sorted_key_table_top #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output skt_pkg::rsp_t rsp
);

  `include "sorted_key_table_top_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = skt_pkg::KEY_W + skt_pkg::YEAR_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_LOOK   = 6'b000100,
    ST_SHUP   = 6'b001000,
    ST_PLACE  = 6'b010000,
    ST_SHDN   = 6'b100000
  } state_t;

  // Result wait is folded into a flag so that the state stays compact
  state_t state, state_next;
  logic   done, done_next;

  skt_pkg::req_t op;
  logic [CW-1:0] lo, lo_next;
  logic [CW-1:0] hi, hi_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] cur, cur_next;
  logic [CW-1:0] fill, fill_next;
  logic          rd_pend, rd_pend_next;
  logic [skt_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic [skt_pkg::YEAR_W-1:0]   res_year, res_year_next;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  skt_pkg::entry_t ram_wdata;
  skt_pkg::entry_t ram_rdata;
  logic [EW-1:0]   ram_rbits;

  logic [CW-1:0] lo_cur, hi_cur;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] lo_inc, cur_dec, cur_dec2, cur_inc, cur_inc2, fill_dec;
  logic          hit, rsp_load;

  skt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = skt_pkg::entry_t'(ram_rbits);

  assign req_ready = (state == ST_IDLE) && !done;
  assign rsp_load  = done && (!rsp_valid || rsp_ready);

  // Narrow the search window with the entry read last cycle
  always_comb begin
    lo_cur = lo;
    hi_cur = hi;
    if (rd_pend) begin
      if (ram_rdata.key < op.key) begin
        lo_cur = mid + CW'(1);
      end else begin
        hi_cur = mid;
      end
    end
  end

  assign mid_sum  = {1'b0, lo_cur} + {1'b0, hi_cur};
  assign lo_inc   = lo + CW'(1);
  assign cur_dec  = cur - CW'(1);
  assign cur_dec2 = cur - CW'(2);
  assign cur_inc  = cur + CW'(1);
  assign cur_inc2 = cur + CW'(2);
  assign fill_dec = fill - CW'(1);
  assign hit      = (lo < fill) && (ram_rdata.key == op.key);

  // Sequence search, shift and write-back
  always_comb begin
    state_next      = state;
    done_next       = done;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    cur_next        = cur;
    fill_next       = fill;
    rd_pend_next    = 1'b0;
    res_status_next = res_status;
    res_year_next   = res_year;
    ram_we          = 1'b0;
    ram_waddr       = cur[AW-1:0];
    ram_wdata       = ram_rdata;
    ram_raddr       = '0;
    unique case (state)
      ST_IDLE: begin
        if (done) begin
          if (rsp_load) begin
            done_next = 1'b0;
          end
        end else if (req_valid) begin
          lo_next       = '0;
          hi_next       = fill;
          res_year_next = '0;
          state_next    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        lo_next = lo_cur;
        hi_next = hi_cur;
        if (lo_cur < hi_cur) begin
          mid_next     = mid_sum[CW:1];
          ram_raddr    = mid_sum[AW:1];
          rd_pend_next = 1'b1;
        end else begin
          // Probe the lower bound for an exact match
          ram_raddr  = lo_cur[AW-1:0];
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        res_status_next = skt_pkg::STATUS_OK;
        state_next      = ST_IDLE;
        done_next       = 1'b1;
        unique case (op.kind)
          skt_pkg::KIND_INSERT: begin
            if (hit) begin
              res_status_next = skt_pkg::STATUS_DUPLICATE;
            end else if (fill == CW'(DEPTH)) begin
              res_status_next = skt_pkg::STATUS_FULL;
            end else if (fill > lo) begin
              cur_next   = fill;
              ram_raddr  = fill_dec[AW-1:0];
              state_next = ST_SHUP;
              done_next  = 1'b0;
            end else begin
              state_next = ST_PLACE;
              done_next  = 1'b0;
            end
          end
          skt_pkg::KIND_REMOVE: begin
            if (!hit) begin
              res_status_next = skt_pkg::STATUS_NOT_FOUND;
            end else if (lo_inc < fill) begin
              cur_next   = lo;
              ram_raddr  = lo_inc[AW-1:0];
              state_next = ST_SHDN;
              done_next  = 1'b0;
            end else begin
              fill_next = fill_dec;
            end
          end
          skt_pkg::KIND_LOOKUP: begin
            if (hit) begin
              res_year_next = ram_rdata.year;
            end else begin
              res_status_next = skt_pkg::STATUS_NOT_FOUND;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SHUP: begin
        // Move one entry up, read the one below it
        ram_we   = 1'b1;
        cur_next = cur_dec;
        if (cur_dec > lo) begin
          ram_raddr = cur_dec2[AW-1:0];
        end else begin
          state_next = ST_PLACE;
        end
      end
      ST_PLACE: begin
        ram_we         = 1'b1;
        ram_waddr      = lo[AW-1:0];
        ram_wdata.key  = op.key;
        ram_wdata.year = op.year;
        fill_next      = fill + CW'(1);
        state_next     = ST_IDLE;
        done_next      = 1'b1;
      end
      ST_SHDN: begin
        // Move one entry down, read the one above it
        ram_we   = 1'b1;
        cur_next = cur_inc;
        if (cur_inc2 < fill) begin
          ram_raddr = cur_inc2[AW-1:0];
        end else begin
          fill_next  = fill_dec;
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      fill    <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= done_next;
      fill    <= fill_next;
      rd_pend <= rd_pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op <= req;
    end
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_year   <= res_year_next;
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= res_status;
      rsp.found_year  <= res_year;
      rsp.entry_count <= skt_pkg::COUNT_W'(fill);
    end
  end

  `SKT_ASSERT(a_fill_bound, fill <= CW'(DEPTH), "fill count exceeds table depth")
  `SKT_ASSERT(a_no_write_idle, !(state == ST_IDLE && ram_we), "RAM written while idle")
  `SKT_ASSERT_NEXT(a_fill_steady, state != ST_LOOK && state != ST_PLACE && state != ST_SHDN, fill == $past(fill), "fill count changed outside an update step")
  `SKT_ASSERT_NEXT(a_rsp_load, rsp_load, rsp_valid, "finished result not presented")
  `SKT_ASSERT_NEXT(a_accept_search, req_valid && req_ready, state == ST_SEARCH, "accepted request did not start a search")

endmodule

/* rtl/skt_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word and register one read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
